// ===== hdl/dccpd_pkg.sv =====
// Package for the DCC packet decoder: request/result structs, config struct,
// operation and service codes, and register indexes.
// No dependencies.
package dccpd_pkg;

	// Largest packet the decoder checks, XOR byte included
	localparam int unsigned DCC_PACKET_BYTES = 6;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 14;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS_KIND = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONSIST_BYTE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SERVICE_MODE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DIR_INVERT       = 3'd4;

	// Operations instruction kinds
	localparam logic [3:0] OP_NONE        = 4'd0;
	localparam logic [3:0] OP_HARD_RESET  = 4'd1;
	localparam logic [3:0] OP_SOFT_RESET  = 4'd2;
	localparam logic [3:0] OP_CONSIST_FWD = 4'd3;
	localparam logic [3:0] OP_CONSIST_REV = 4'd4;
	localparam logic [3:0] OP_ESTOP       = 4'd5;
	localparam logic [3:0] OP_SPEED128    = 4'd6;
	localparam logic [3:0] OP_SPEED28     = 4'd7;
	localparam logic [3:0] OP_FUNC_F0_F4  = 4'd8;
	localparam logic [3:0] OP_FUNC_F5_F8  = 4'd9;
	localparam logic [3:0] OP_FUNC_F9_F12 = 4'd10;
	localparam logic [3:0] OP_OPS_CV      = 4'd11;

	// Service-mode classes
	localparam logic [1:0] SVC_NONE   = 2'd0;
	localparam logic [1:0] SVC_OTHER  = 2'd1;
	localparam logic [1:0] SVC_DIRECT = 2'd2;
	localparam logic [1:0] SVC_PAGED  = 2'd3;

	// CV access field codes (instruction bits 3:2)
	localparam logic [1:0] CV_ACC_VERIFY = 2'b01;
	localparam logic [1:0] CV_ACC_BIT    = 2'b10;
	localparam logic [1:0] CV_ACC_WRITE  = 2'b11;

	// Address ranges
	localparam logic [7:0] ADDR_BROADCAST = 8'h00;
	localparam logic [7:0] ADDR_IDLE      = 8'hFF;
	localparam logic [7:0] ADDR_LONG_MAX  = 8'hE7;

	// Instruction groups (header bits 7:5)
	localparam logic [2:0] GRP_CONTROL  = 3'd0;
	localparam logic [2:0] GRP_ADVANCED = 3'd1;
	localparam logic [2:0] GRP_REVERSE  = 3'd2;
	localparam logic [2:0] GRP_FORWARD  = 3'd3;
	localparam logic [2:0] GRP_FUNC_ONE = 3'd4;
	localparam logic [2:0] GRP_FUNC_TWO = 3'd5;
	localparam logic [2:0] GRP_CV       = 3'd7;

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
		logic [7:0] byte5;
		logic [2:0] length;
	} dccpd_packet_t;

	typedef struct packed {
		logic              check_ok;
		logic [13:0]       address;
		logic              address_kind;
		logic [1:0]        service_class;
		logic              cv_verify;
		logic              cv_write;
		logic              cv_bit_op;
		logic [3:0]        op_kind;
		logic signed [7:0] speed;
	} dccpd_result_t;

	typedef struct packed {
		logic [13:0] own_address;
		logic        own_address_kind;
		logic [7:0]  consist_byte;
		logic        service_mode;
		logic        dir_invert;
	} dccpd_cfg_t;

endpackage

// ===== hdl/dccpd_decode.sv =====
// Combinational packet decode: XOR check, address, service class, CV flags,
// operation kind and signed speed. Depends on dccpd_pkg.
module dccpd_decode (
	input  dccpd_pkg::dccpd_packet_t pkt,
	input  dccpd_pkg::dccpd_cfg_t    cfg,
	output dccpd_pkg::dccpd_result_t res
);
	import dccpd_pkg::*;

	typedef struct packed {
		logic ver;
		logic wr;
		logic bit_op;
	} cv_flags_t;

	// CV access flags from an instruction byte and the data byte two later
	function automatic cv_flags_t cv_access(input logic [7:0] instr, input logic [7:0] data);
		cv_flags_t f;
		f = '0;
		case (instr[3:2])
			CV_ACC_VERIFY: f.ver = 1'b1;
			CV_ACC_WRITE:  f.wr  = 1'b1;
			CV_ACC_BIT: begin
				f.bit_op = 1'b1;
				if (data[4])
					f.wr = 1'b1;
				else
					f.ver = 1'b1;
			end
			default: f = '0;
		endcase
		return f;
	endfunction

	logic [7:0]        b0;
	logic [2:0]        len;
	logic              is_long;
	logic              consist_on;
	logic [7:0]        hdr;
	logic [7:0]        nxt;
	logic [7:0]        cv_data;
	logic [3:0]        step;
	logic              apply_flips;
	logic              flip;
	logic signed [7:0] spd;
	cv_flags_t         cvf;

	assign b0         = pkt.byte0;
	assign len        = pkt.length;
	assign is_long    = (b0[7:6] == 2'b11) && (b0 <= ADDR_LONG_MAX);
	assign consist_on = (cfg.consist_byte[6:0] != 7'd0);
	assign hdr        = is_long ? pkt.byte2 : pkt.byte1;
	assign nxt        = is_long ? pkt.byte3 : pkt.byte2;
	assign cv_data    = is_long ? pkt.byte4 : pkt.byte3;
	assign step       = hdr[3:0];
	assign flip       = cfg.dir_invert ^ (consist_on & cfg.consist_byte[7]);

	always_comb begin
		res         = '0;
		spd         = '0;
		apply_flips = 1'b1;
		cvf         = '0;

		// XOR check over the bytes before the last one
		if (len >= 3'd3 && 32'(len) <= DCC_PACKET_BYTES) begin
			case (len)
				3'd3: res.check_ok = ((b0 ^ pkt.byte1) == pkt.byte2);
				3'd4: res.check_ok = ((b0 ^ pkt.byte1 ^ pkt.byte2) == pkt.byte3);
				3'd5: res.check_ok = ((b0 ^ pkt.byte1 ^ pkt.byte2 ^ pkt.byte3) == pkt.byte4);
				3'd6: res.check_ok = ((b0 ^ pkt.byte1 ^ pkt.byte2 ^ pkt.byte3 ^ pkt.byte4)
					== pkt.byte5);
				default: res.check_ok = 1'b0;
			endcase
		end

		// Address: broadcast, long, reserved long range, or short
		if (b0 == ADDR_IDLE || b0 == ADDR_BROADCAST) begin
			res.address      = consist_on ? {7'd0, cfg.consist_byte[6:0]} : cfg.own_address;
			res.address_kind = cfg.own_address_kind;
		end else if (b0[7:6] == 2'b11) begin
			if (is_long) begin
				res.address      = {b0[5:0], pkt.byte1};
				res.address_kind = 1'b1;
			end
		end else begin
			res.address = {6'd0, b0};
		end

		// Service mode or operations instruction
		if (cfg.service_mode && b0[6:4] == 3'b111) begin
			if (len == 3'd4) begin
				res.service_class = SVC_DIRECT;
				cvf = cv_access(b0, pkt.byte2);
			end else if (len == 3'd3) begin
				res.service_class = SVC_PAGED;
				if (b0[3])
					cvf.wr = 1'b1;
				else
					cvf.ver = 1'b1;
			end else begin
				res.service_class = SVC_OTHER;
			end
		end else if (b0 != ADDR_IDLE) begin
			case (hdr[7:5])
				GRP_CONTROL: begin
					if (!hdr[4]) begin
						if (hdr[3:1] == 3'd0)
							res.op_kind = hdr[0] ? OP_HARD_RESET : OP_SOFT_RESET;
					end else if (len >= 3'd4) begin
						if (hdr[3:0] == 4'd2)
							res.op_kind = OP_CONSIST_FWD;
						else if (hdr[3:0] == 4'd3)
							res.op_kind = OP_CONSIST_REV;
					end
				end
				GRP_ADVANCED: begin
					if (hdr[4:0] == 5'h1F) begin
						if (nxt[6:0] == 7'd1) begin
							res.op_kind = OP_ESTOP;
							spd = nxt[7] ? 8'sd1 : -8'sd1;
						end else begin
							res.op_kind = OP_SPEED128;
							if (len <= 3'd3) begin
								apply_flips = 1'b0;
							end else begin
								spd = (nxt[6:0] != 7'd0) ? $signed({1'b0, nxt[6:0]}) : 8'sd1;
								if (!nxt[7])
									spd = -spd;
							end
						end
					end
				end
				GRP_REVERSE, GRP_FORWARD: begin
					if (step == 4'd1) begin
						res.op_kind = OP_ESTOP;
						spd = 8'sd1;
					end else begin
						res.op_kind = OP_SPEED28;
						// 28-step table: 2*(step-1) plus the intermediate bit
						spd = (step < 4'd2) ? 8'sd1 : $signed({3'd0, step - 4'd1, hdr[4]});
					end
					if (!hdr[5])
						spd = -spd;
				end
				GRP_FUNC_ONE: res.op_kind = OP_FUNC_F0_F4;
				GRP_FUNC_TWO: res.op_kind = hdr[4] ? OP_FUNC_F5_F8 : OP_FUNC_F9_F12;
				GRP_CV: begin
					if (!hdr[4]) begin
						res.op_kind = OP_OPS_CV;
						cvf = cv_access(hdr, cv_data);
					end
				end
				default: res.op_kind = OP_NONE;
			endcase
		end

		// Direction flips from the invert setting and a reverse-facing consist
		if (apply_flips && flip)
			spd = -spd;

		res.cv_verify = cvf.ver;
		res.cv_write  = cvf.wr;
		res.cv_bit_op = cvf.bit_op;
		res.speed     = spd;
	end

endmodule

// ===== hdl/dcc_packet_decode.sv =====
// DCC command packet decoder, top level: config registers, input register,
// result register. Depends on dccpd_pkg and dccpd_decode.
//
// A packet request is taken on any cycle with start high; busy is never
// raised, so a new packet may follow every cycle. Each packet gives exactly
// one result (input register, then decode into the result register), shown
// on result for one cycle with done high. The receiver cannot stall, so
// results must be captured when done is high. Config registers are written
// through cfg_we/cfg_index/cfg_data, by the user only while no packet is in
// flight, which the block does not enforce; writes past the last index are ignored.
module dcc_packet_decode (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  dccpd_pkg::dccpd_packet_t               packet,
	output logic                                   done,
	output dccpd_pkg::dccpd_result_t               result,
	input  logic                                   cfg_we,
	input  logic [dccpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dccpd_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import dccpd_pkg::*;

	dccpd_cfg_t    cfg_q;
	dccpd_packet_t pkt_s1;
	logic          valid_s1;
	dccpd_result_t dec_res;
	dccpd_result_t res_s2;
	logic          valid_s2;
	logic          take;

	assign busy = 1'b0;
	assign take = start & ~busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address      <= 14'd3;
			cfg_q.own_address_kind <= 1'b0;
			cfg_q.consist_byte     <= 8'd0;
			cfg_q.service_mode     <= 1'b0;
			cfg_q.dir_invert       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ADDRESS:      cfg_q.own_address      <= cfg_data;
				CFG_OWN_ADDRESS_KIND: cfg_q.own_address_kind <= cfg_data[0];
				CFG_CONSIST_BYTE:     cfg_q.consist_byte     <= cfg_data[7:0];
				CFG_SERVICE_MODE:     cfg_q.service_mode     <= cfg_data[0];
				CFG_DIR_INVERT:       cfg_q.dir_invert       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pkt_s1 <= packet;
		end
	end

	dccpd_decode u_decode (
		.pkt (pkt_s1),
		.cfg (cfg_q),
		.res (dec_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign done   = valid_s2;
	assign result = res_s2;

endmodule
